[src/rkc_pkg.sv]
package rkc_pkg;

	// Pixel: three 8-bit channels, channel 0 in the lowest byte.
	typedef logic [2:0][7:0] pix_t;

	localparam int NUM_CH       = 3;
	localparam int PIX_W        = 24;
	localparam int COEF_W       = 12;
	localparam int COEF_ROWS    = 5;
	localparam int COEF_ROW_W   = 60;
	localparam int MAX_HEIGHT   = 4096;

	// Configuration register indexes (byte address is eight times the index).
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_KERNEL_RADIUS,
		REG_COEF_ROW_0,
		REG_COEF_ROW_1,
		REG_COEF_ROW_2,
		REG_COEF_ROW_3,
		REG_COEF_ROW_4
	} reg_idx_t;

	// Reset kernel: -1,-1,-1 / 2,2,2 / -1,-1,-1 in Q4.8.
	localparam logic [COEF_ROW_W-1:0] COEF_EDGE_RST = 60'd64440241920;
	localparam logic [COEF_ROW_W-1:0] COEF_MID_RST  = 60'd8592032256;

	// Image geometry as used after clamping.
	typedef struct packed {
		logic [11:0] width;
		logic [12:0] height;
		logic [1:0]  radius;
	} geom_t;

	// Position of the output pixel that a window belongs to.
	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
	} job_t;

endpackage

[src/rgb_kernel_convolution_unit.sv]
// Channel     Role      Beat
// s_axis      input     tdata = three 8-bit channels, tuser = discard flag
// m_axis      output    tdata = three filtered channels, tlast = frame end
// apb         config    64-bit registers at byte address 8*index
//
// One beat is taken per clock when the output side keeps up. A result is valid
// once the beat that completes its window has passed the pipeline registers:
// the line store is read at the accepting edge, then the window shift, the products,
// the row sums and the final sum each take one register. Reset clears the
// configuration, the counters and the stage valid flags only; the input is
// held off until the init flag sets after reset. The line store needs no
// clearing because taps above the image are masked. A stalled output holds
// each stage in turn; input is taken until the stages behind it are full.
module rgb_kernel_convolution_unit #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH = 2048,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // chan0_in, chan1_in, chan2_in
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // chan0_out, chan1_out, chan2_out
	output logic        m_axis_tlast    // frame_last
);

	localparam int RMAX  = (MAX_KERNEL - 1) / 2;
	localparam int KMAX  = 2 * RMAX + 1;
	localparam int LINES = (KMAX > 1) ? KMAX - 1 : 1;
	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW    = LINES * rkc_pkg::PIX_W;
	localparam int NW    = 25;

	// Configuration registers.
	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [1:0]  radius_q;
	logic [rkc_pkg::COEF_ROW_W-1:0] coef_q [rkc_pkg::COEF_ROWS];
	rkc_pkg::reg_idx_t reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = rkc_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 12'd640;
			height_q  <= 13'd480;
			radius_q  <= 2'd1;
			coef_q[0] <= rkc_pkg::COEF_EDGE_RST;
			coef_q[1] <= rkc_pkg::COEF_MID_RST;
			coef_q[2] <= rkc_pkg::COEF_EDGE_RST;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rkc_pkg::REG_IMAGE_WIDTH:   width_q  <= pwdata[11:0];
				rkc_pkg::REG_IMAGE_HEIGHT:  height_q <= pwdata[12:0];
				rkc_pkg::REG_KERNEL_RADIUS: radius_q <= pwdata[1:0];
				rkc_pkg::REG_COEF_ROW_0:    coef_q[0] <= pwdata[59:0];
				rkc_pkg::REG_COEF_ROW_1:    coef_q[1] <= pwdata[59:0];
				rkc_pkg::REG_COEF_ROW_2:    coef_q[2] <= pwdata[59:0];
				rkc_pkg::REG_COEF_ROW_3:    coef_q[3] <= pwdata[59:0];
				rkc_pkg::REG_COEF_ROW_4:    coef_q[4] <= pwdata[59:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			rkc_pkg::REG_IMAGE_WIDTH:   prdata = {52'd0, width_q};
			rkc_pkg::REG_IMAGE_HEIGHT:  prdata = {51'd0, height_q};
			rkc_pkg::REG_KERNEL_RADIUS: prdata = {62'd0, radius_q};
			rkc_pkg::REG_COEF_ROW_0:    prdata = {4'd0, coef_q[0]};
			rkc_pkg::REG_COEF_ROW_1:    prdata = {4'd0, coef_q[1]};
			rkc_pkg::REG_COEF_ROW_2:    prdata = {4'd0, coef_q[2]};
			rkc_pkg::REG_COEF_ROW_3:    prdata = {4'd0, coef_q[3]};
			rkc_pkg::REG_COEF_ROW_4:    prdata = {4'd0, coef_q[4]};
			default:                    prdata = '0;
		endcase
	end

	// Clamped geometry.
	rkc_pkg::geom_t geom;

	always_comb begin
		if (width_q == 12'd0) begin
			geom.width = 12'd1;
		end else if (int'(width_q) > MAX_WIDTH) begin
			geom.width = 12'(MAX_WIDTH);
		end else begin
			geom.width = width_q;
		end
		if (height_q == 13'd0) begin
			geom.height = 13'd1;
		end else if (int'(height_q) > rkc_pkg::MAX_HEIGHT) begin
			geom.height = 13'(rkc_pkg::MAX_HEIGHT);
		end else begin
			geom.height = height_q;
		end
		geom.radius = (int'(radius_q) > RMAX) ? 2'(RMAX) : radius_q;
	end

	// Frame size and the lag from input to output.
	logic [23:0] frame_total;
	logic [13:0] frame_lag;
	logic        init_q;

	always_comb begin
		frame_total = 24'(geom.width) * 24'(geom.height);
		case (geom.radius)
			2'd1:    frame_lag = 14'(geom.width) + 14'd1;
			2'd2:    frame_lag = {1'b0, geom.width, 1'b0} + 14'd2;
			default: frame_lag = 14'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= 1'b0;
		else         init_q <= 1'b1;
	end

	// Stream position counters.
	logic [NW-1:0] n_q, n_e;
	logic [11:0]   in_col_q, col_e;
	logic [23:0]   out_cnt_q, ocnt_e;
	logic [11:0]   out_row_q, orow_e, out_col_q, ocol_e;
	logic          abandon, pixel_phase, drop, store, emit, last;
	logic          accept;
	logic          s1_v, s1_adv, wv_q, mac_ready;

	assign s_axis_tready = init_q && (!s1_v || s1_adv);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// A frame left inconsistent by a configuration change restarts from zero.
	always_comb begin
		abandon = (out_cnt_q >= frame_total) ||
			(n_q > (NW'(frame_total) + NW'(frame_lag)));
		n_e    = abandon ? '0 : n_q;
		col_e  = abandon ? '0 : in_col_q;
		ocnt_e = abandon ? '0 : out_cnt_q;
		orow_e = abandon ? '0 : out_row_q;
		ocol_e = abandon ? '0 : out_col_q;
		pixel_phase = n_e < NW'(frame_total);
		drop  = pixel_phase && s_axis_tuser;
		store = !drop;
		emit  = n_e >= NW'(frame_lag);
		last  = emit && ((NW'(ocnt_e) + NW'(1)) >= NW'(frame_total));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			in_col_q  <= '0;
			out_cnt_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (drop || last) begin
				n_q       <= last ? '0 : n_e;
				in_col_q  <= last ? '0 : col_e;
				out_cnt_q <= last ? '0 : ocnt_e;
				out_row_q <= last ? '0 : orow_e;
				out_col_q <= last ? '0 : ocol_e;
			end else begin
				n_q <= n_e + NW'(1);
				if ((13'(col_e) + 13'd1) >= 13'(geom.width)) in_col_q <= '0;
				else                                          in_col_q <= col_e + 12'd1;
				if (emit) begin
					out_cnt_q <= ocnt_e + 24'd1;
					if ((13'(ocol_e) + 13'd1) >= 13'(geom.width)) begin
						out_col_q <= '0;
						out_row_q <= orow_e + 12'd1;
					end else begin
						out_col_q <= ocol_e + 12'd1;
						out_row_q <= orow_e;
					end
				end else begin
					out_cnt_q <= ocnt_e;
					out_row_q <= orow_e;
					out_col_q <= ocol_e;
				end
			end
		end
	end

	// Line store: one entry per column, holding the pixels of earlier rows.
	logic [LW-1:0]  line_mem_q [MAX_WIDTH];
	logic [LW-1:0]  rd_q, old_line, wr_line, fwd_data_s1;
	logic [AW-1:0]  rd_addr, s1_addr;
	logic           mem_re, fwd_s1;
	rkc_pkg::pix_t  s1_pix, in_pix;
	rkc_pkg::pix_t  col_vec [KMAX];
	logic           s1_emit;
	rkc_pkg::job_t  s1_job, win_job_q;

	assign rd_addr = AW'(col_e);
	assign mem_re  = accept && store;
	assign in_pix  = pixel_phase ? s_axis_tdata : '0;

	always_ff @(posedge clk) begin
		if (s1_adv) line_mem_q[s1_addr] <= wr_line;
		if (mem_re) rd_q <= line_mem_q[rd_addr];
	end

	// Column of the newest beat: new pixel on top, older rows below it.
	always_comb begin
		old_line = fwd_s1 ? fwd_data_s1 : rd_q;
		col_vec[0] = s1_pix;
		for (int k = 1; k < KMAX; k++) begin
			col_vec[k] = old_line[(k-1)*rkc_pkg::PIX_W +: rkc_pkg::PIX_W];
		end
		wr_line[rkc_pkg::PIX_W-1:0] = s1_pix;
		for (int k = 1; k < LINES; k++) begin
			wr_line[k*rkc_pkg::PIX_W +: rkc_pkg::PIX_W] =
				old_line[(k-1)*rkc_pkg::PIX_W +: rkc_pkg::PIX_W];
		end
	end

	// Read stage; a read of the entry being written back takes the new data.
	assign s1_adv = s1_v && (!wv_q || mac_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			wv_q <= 1'b0;
		end else begin
			if (mem_re)      s1_v <= 1'b1;
			else if (s1_adv) s1_v <= 1'b0;
			if (s1_adv)         wv_q <= s1_emit;
			else if (mac_ready) wv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			s1_pix      <= in_pix;
			s1_addr     <= rd_addr;
			s1_emit     <= emit;
			s1_job      <= '{row: orow_e, col: ocol_e, last: last};
			fwd_s1      <= s1_adv && (s1_addr == rd_addr);
			fwd_data_s1 <= wr_line;
		end
		if (s1_adv) begin
			win_job_q <= s1_job;
		end
	end

	// Window registers: column 0 is the newest beat, row 0 the newest row.
	rkc_pkg::pix_t win_q [KMAX][KMAX];

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < KMAX; k++) begin
				for (int c = KMAX - 1; c > 0; c--) begin
					win_q[k][c] <= win_q[k][c-1];
				end
				win_q[k][0] <= col_vec[k];
			end
		end
	end

	rkc_pkg::pix_t out_pix;

	rkc_window_mac #(
		.KMAX(KMAX),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(wv_q),
		.in_ready(mac_ready),
		.win(win_q),
		.job(win_job_q),
		.geom(geom),
		.coef(coef_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_pix(out_pix),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = out_pix;

endmodule

[src/rkc_window_mac.sv]
module rkc_window_mac #(
	parameter int KMAX = 5,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rkc_pkg::pix_t                     win [KMAX][KMAX],
	input  rkc_pkg::job_t                     job,
	input  rkc_pkg::geom_t                    geom,
	input  logic [rkc_pkg::COEF_ROW_W-1:0]    coef [rkc_pkg::COEF_ROWS],
	output logic                              out_valid,
	input  logic                              out_ready,
	output rkc_pkg::pix_t                     out_pix,
	output logic                              out_last
);

	localparam int KB = (KMAX > 1) ? $clog2(KMAX) : 1;
	localparam int PW = rkc_pkg::COEF_W + 9;
	localparam int RW = PW + 3;
	localparam int SW = PW + 6;
	localparam logic signed [SW-1:0] HALF = SW'((1 << COEF_FRAC_BITS) >> 1);

	logic signed [PW-1:0] prod_d  [rkc_pkg::NUM_CH][KMAX][KMAX];
	logic signed [PW-1:0] prod_s1 [rkc_pkg::NUM_CH][KMAX][KMAX];
	logic signed [RW-1:0] rsum_d  [rkc_pkg::NUM_CH][KMAX];
	logic signed [RW-1:0] rsum_s2 [rkc_pkg::NUM_CH][KMAX];
	logic                 pv_s1, rv_s2, ov_q;
	logic                 last_s1, last_s2, last_q;
	rkc_pkg::pix_t        pix_d, pix_q;
	logic                 p_ready, r_ready, o_ready;

	// Each stage moves on when the stage after it is empty or moving.
	assign o_ready  = !ov_q || out_ready;
	assign r_ready  = !rv_s2 || o_ready;
	assign p_ready  = !pv_s1 || r_ready;
	assign in_ready = p_ready;

	// Masked taps: a tap outside the kernel or outside the image weighs nothing.
	always_comb begin
		logic signed [14:0] rr, cc;
		logic               row_ok, col_ok;
		logic [KB-1:0]      ki, kj;
		logic signed [rkc_pkg::COEF_W-1:0] k;
		for (int i = 0; i < KMAX; i++) begin
			rr = $signed({3'b000, job.row}) + 15'(i) - $signed({13'd0, geom.radius});
			row_ok = (i <= 2 * int'(geom.radius)) && (rr >= 0) &&
				(rr < $signed({2'b00, geom.height}));
			ki = row_ok ? KB'(2 * int'(geom.radius) - i) : '0;
			for (int j = 0; j < KMAX; j++) begin
				cc = $signed({3'b000, job.col}) + 15'(j) - $signed({13'd0, geom.radius});
				col_ok = (j <= 2 * int'(geom.radius)) && (cc >= 0) &&
					(cc < $signed({3'b000, geom.width}));
				kj = col_ok ? KB'(2 * int'(geom.radius) - j) : '0;
				k = $signed(coef[i][rkc_pkg::COEF_W*j +: rkc_pkg::COEF_W]);
				for (int ch = 0; ch < rkc_pkg::NUM_CH; ch++) begin
					if (row_ok && col_ok) begin
						prod_d[ch][i][j] = PW'($signed({1'b0, win[ki][kj][ch]}) * k);
					end else begin
						prod_d[ch][i][j] = '0;
					end
				end
			end
		end
	end

	// Row sums over the registered products.
	always_comb begin
		for (int ch = 0; ch < rkc_pkg::NUM_CH; ch++) begin
			for (int i = 0; i < KMAX; i++) begin
				rsum_d[ch][i] = '0;
				for (int j = 0; j < KMAX; j++) begin
					rsum_d[ch][i] = rsum_d[ch][i] + RW'(prod_s1[ch][i][j]);
				end
			end
		end
	end

	// Final sum, round half up and saturate to 0..255.
	always_comb begin
		logic signed [SW-1:0] t;
		logic signed [SW-1:0] v;
		for (int ch = 0; ch < rkc_pkg::NUM_CH; ch++) begin
			t = HALF;
			for (int i = 0; i < KMAX; i++) begin
				t = t + SW'(rsum_s2[ch][i]);
			end
			v = t >>> COEF_FRAC_BITS;
			if (t < 0) begin
				pix_d[ch] = 8'd0;
			end else if (v > 255) begin
				pix_d[ch] = 8'd255;
			end else begin
				pix_d[ch] = v[7:0];
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (p_ready) pv_s1 <= in_valid;
			if (r_ready) rv_s2 <= pv_s1;
			if (o_ready) ov_q  <= rv_s2;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (p_ready && in_valid) begin
			prod_s1 <= prod_d;
			last_s1 <= job.last;
		end
		if (r_ready && pv_s1) begin
			rsum_s2 <= rsum_d;
			last_s2 <= last_s1;
		end
		if (o_ready && rv_s2) begin
			pix_q  <= pix_d;
			last_q <= last_s2;
		end
	end

	assign out_valid = ov_q;
	assign out_pix   = pix_q;
	assign out_last  = last_q;

endmodule
